[design/aias_pkg.sv]
// Package for the array insert and statistics block.
// Holds command and status codes, field widths and the controller/datapath structs.
// No dependencies.
`default_nettype none
package aias_pkg;

    localparam int CMD_W   = 2;
    localparam int VAL_W   = 32;
    localparam int POS_W   = 8;
    localparam int STAT_W  = 2;
    localparam int LEN_W   = 8;
    localparam int EVEN_W  = 39;
    localparam int PRIME_W = 38;
    localparam int CNT_W   = 8;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 160;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REPORT = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic load;
        logic rd_prev;
        logic rd_cur;
        logic wr_shift;
        logic wr_value;
        logic idx_dec;
        logic idx_inc;
        logic prime_start;
        logic acc_add;
    } t_dp_cmd;

    typedef struct packed {
        logic insert_ok;
        logic report_ok;
        logic idx_eq_pos;
        logic idxm1_eq_pos;
        logic idx_last;
        logic prime_done;
    } t_dp_stat;

    typedef struct packed {
        logic [CNT_W-1:0]   match_count;
        logic [VAL_W-1:0]   max_value;
        logic [VAL_W-1:0]   min_value;
        logic [PRIME_W-1:0] prime_sum;
        logic [EVEN_W-1:0]  even_sum;
        logic [LEN_W-1:0]   length;
        logic [STAT_W-1:0]  status;
    } t_result;

endpackage
`default_nettype wire

[design/array_insert_and_statistics.sv]
// Usage: top level of the ordered store with insert and statistics report.
// Each request on the slave channel carries a command (clear, insert, report), a value
// and a position; exactly one result request leaves on the master channel for each.
// Input tdata: command, value, position. Output tdata: status, length, even sum,
// prime sum, minimum, maximum and match count.
// One request is worked on at a time. Clear, unused commands, rejected inserts and a
// report on an empty store go from the decide state straight to the result. An insert at
// position p into a store of length L shifts the L - p entries from p upward, one memory
// read and one write per shifted entry, then writes the value. A report reads each entry
// in turn and tests it for primality by trial division; entries below 2 try no divisor.
// The next request can be accepted once the earlier result is in the output register.
// The result sits in an output register; the next request is accepted while it waits,
// but its result is held back until the earlier one has been taken.
// After reset the store is empty; memory contents are not cleared and need no pass.
// A stalled receiver simply holds the result and, in time, the input side.
// Depends on aias_pkg, aias_ctrl, aias_dp and aias_prime.
`default_nettype none
module array_insert_and_statistics #(
    parameter int DEPTH = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // Fields from bit 0: command[1:0], value[33:2], position[41:34], zero fill.
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // Fields from bit 0: status[1:0], length[9:2], even_sum[48:10], prime_sum[86:49],
    // min_value[118:87], max_value[150:119], match_count[158:151], zero fill.
    output logic [159:0]     m_axis_tdata
);
    import aias_pkg::*;

    t_dp_cmd          dp_cmd;
    t_dp_stat         dp_stat;
    t_result          result;
    logic             out_load;
    logic             out_free;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    assign out_free = !r_out_valid || m_axis_tready;

    aias_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (out_free),
        .i_stat     (dp_stat),
        .o_in_ready (s_axis_tready),
        .o_out_load (out_load),
        .o_cmd      (dp_cmd)
    );

    aias_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_command  (s_axis_tdata[1:0]),
        .i_value    (s_axis_tdata[33:2]),
        .i_position (s_axis_tdata[41:34]),
        .o_stat     (dp_stat),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {1'b0, result};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire

[design/aias_prime.sv]
// Trial-division primality unit: one remainder bit per cycle, squares kept incrementally.
// Depends on aias_pkg.
`default_nettype none
module aias_prime (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [aias_pkg::VAL_W-1:0] i_n,
    output logic                          o_done,
    output logic                          o_prime
);
    import aias_pkg::*;

    typedef enum logic [3:0] {
        P_IDLE = 4'b0001,
        P_CHK  = 4'b0010,
        P_DIV  = 4'b0100,
        P_DONE = 4'b1000
    } t_pstate;

    t_pstate     r_state, n_state;
    logic [30:0] r_n;
    logic [15:0] r_d;
    logic [33:0] r_sq;
    logic [15:0] r_rem;
    logic [4:0]  r_bit;
    logic        r_prime, n_prime;
    logic [16:0] rem_sh;
    logic [16:0] rem_new;

    assign rem_sh  = {r_rem, r_n[r_bit]};
    assign rem_new = (rem_sh >= {1'b0, r_d}) ? rem_sh - {1'b0, r_d} : rem_sh;

    always_comb begin
        n_state = r_state;
        n_prime = r_prime;
        unique case (r_state)
            P_IDLE: begin
                if (i_start) begin
                    if ($signed(i_n) < 32'sd2) begin
                        n_prime = 1'b0;
                        n_state = P_DONE;
                    end else begin
                        n_state = P_CHK;
                    end
                end
            end
            P_CHK: begin
                if (r_sq > {3'b000, r_n}) begin
                    n_prime = 1'b1;
                    n_state = P_DONE;
                end else begin
                    n_state = P_DIV;
                end
            end
            P_DIV: begin
                if (r_bit == 5'd0) begin
                    if (rem_new == 17'd0) begin
                        n_prime = 1'b0;
                        n_state = P_DONE;
                    end else begin
                        n_state = P_CHK;
                    end
                end
            end
            P_DONE: n_state = P_IDLE;
            default: n_state = P_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_IDLE;
            r_prime <= 1'b0;
        end else begin
            r_state <= n_state;
            r_prime <= n_prime;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == P_IDLE && i_start) begin
            r_n  <= i_n[30:0];
            r_d  <= 16'd2;
            r_sq <= 34'd4;
        end
        if (r_state == P_CHK) begin
            r_rem <= 16'd0;
            r_bit <= 5'd30;
        end
        if (r_state == P_DIV) begin
            r_rem <= rem_new[15:0];
            r_bit <= r_bit - 5'd1;
            if (r_bit == 5'd0) begin
                r_d  <= r_d + 16'd1;
                r_sq <= r_sq + {17'd0, r_d, 1'b0} + 34'd1;
            end
        end
    end

    assign o_done  = (r_state == P_DONE);
    assign o_prime = r_prime;

endmodule
`default_nettype wire

[design/aias_dp.sv]
// Datapath: element memory, length, address counter, statistics accumulators.
// Depends on aias_pkg and aias_prime.
`default_nettype none
module aias_dp #(
    parameter int DEPTH = 128
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire aias_pkg::t_dp_cmd            i_cmd,
    input  wire logic [aias_pkg::CMD_W-1:0]   i_command,
    input  wire logic [aias_pkg::VAL_W-1:0]   i_value,
    input  wire logic [aias_pkg::POS_W-1:0]   i_position,
    output aias_pkg::t_dp_stat                o_stat,
    output aias_pkg::t_result                 o_result
);
    import aias_pkg::*;

    localparam int LW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = (LW > POS_W) ? LW : POS_W;

    logic [VAL_W-1:0]   mem [DEPTH];
    logic [LW-1:0]      r_len;
    logic [AW-1:0]      r_idx;
    logic [VAL_W-1:0]   r_val;
    logic [POS_W-1:0]   r_pos;
    logic [STAT_W-1:0]  r_status;
    logic               r_insert_ok;
    logic               r_report_ok;
    logic [VAL_W-1:0]   r_rdata;
    logic [EVEN_W-1:0]  r_even;
    logic [PRIME_W-1:0] r_prime;
    logic [VAL_W-1:0]   r_min;
    logic [VAL_W-1:0]   r_max;
    logic [CNT_W-1:0]   r_match;
    logic               full;
    logic               bad_pos;
    logic               is_first;
    logic [AW-1:0]      idx_m1;
    logic               prime_done;
    logic               prime_flag;

    assign full     = (r_len >= LW'(DEPTH));
    assign bad_pos  = (CW'(i_position) > CW'(r_len));
    assign is_first = (r_idx == '0);
    assign idx_m1   = r_idx - AW'(1);

    aias_prime u_prime (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.prime_start),
        .i_n     (r_rdata),
        .o_done  (prime_done),
        .o_prime (prime_flag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cmd.load && i_command == CMD_CLEAR) begin
            r_len <= '0;
        end else if (i_cmd.wr_value) begin
            r_len <= r_len + LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_shift) begin
            mem[r_idx] <= r_rdata;
        end else if (i_cmd.wr_value) begin
            mem[r_idx] <= r_val;
        end
        if (i_cmd.rd_prev) begin
            r_rdata <= mem[idx_m1];
        end else if (i_cmd.rd_cur) begin
            r_rdata <= mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val       <= i_value;
            r_pos       <= i_position;
            r_idx       <= (i_command == CMD_INSERT) ? AW'(r_len) : '0;
            r_insert_ok <= (i_command == CMD_INSERT) && !full && !bad_pos;
            r_report_ok <= (i_command == CMD_REPORT) && (r_len != '0);
            priority if (i_command == CMD_INSERT && full) begin
                r_status <= ST_FULL;
            end else if (i_command == CMD_INSERT && bad_pos) begin
                r_status <= ST_BADPOS;
            end else if (i_command == CMD_REPORT && r_len == '0) begin
                r_status <= ST_EMPTY;
            end else begin
                r_status <= ST_OK;
            end
            r_even  <= '0;
            r_prime <= '0;
            r_min   <= '0;
            r_max   <= '0;
            r_match <= '0;
        end else begin
            if (i_cmd.idx_dec) begin
                r_idx <= idx_m1;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + AW'(1);
            end
            if (i_cmd.acc_add) begin
                if (!r_rdata[0]) begin
                    r_even <= r_even + EVEN_W'($signed(r_rdata));
                end
                if (prime_flag) begin
                    r_prime <= r_prime + PRIME_W'(r_rdata);
                end
                if (is_first || $signed(r_rdata) < $signed(r_min)) begin
                    r_min <= r_rdata;
                end
                if (is_first || $signed(r_rdata) > $signed(r_max)) begin
                    r_max <= r_rdata;
                end
                if (r_rdata == r_val) begin
                    r_match <= r_match + CNT_W'(1);
                end
            end
        end
    end

    assign o_stat.insert_ok    = r_insert_ok;
    assign o_stat.report_ok    = r_report_ok;
    assign o_stat.idx_eq_pos   = (CW'(r_idx) == CW'(r_pos));
    assign o_stat.idxm1_eq_pos = (CW'(idx_m1) == CW'(r_pos));
    assign o_stat.idx_last     = (LW'(r_idx) + LW'(1) == r_len);
    assign o_stat.prime_done   = prime_done;

    assign o_result.status      = r_status;
    assign o_result.length      = LEN_W'(r_len);
    assign o_result.even_sum    = r_even;
    assign o_result.prime_sum   = r_prime;
    assign o_result.min_value   = r_min;
    assign o_result.max_value   = r_max;
    assign o_result.match_count = r_match;

endmodule
`default_nettype wire

[design/aias_ctrl.sv]
// Controller state machine: sequences shifting inserts and report scans.
// Depends on aias_pkg.
`default_nettype none
module aias_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_out_free,
    input  wire aias_pkg::t_dp_stat   i_stat,
    output logic                      o_in_ready,
    output logic                      o_out_load,
    output aias_pkg::t_dp_cmd         o_cmd
);
    import aias_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECIDE = 9'b000000010,
        S_SH_RD  = 9'b000000100,
        S_SH_WR  = 9'b000001000,
        S_WRITE  = 9'b000010000,
        S_RD     = 9'b000100000,
        S_RD_W   = 9'b001000000,
        S_PRIME  = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                priority if (i_stat.insert_ok) begin
                    n_state = i_stat.idx_eq_pos ? S_WRITE : S_SH_RD;
                end else if (i_stat.report_ok) begin
                    n_state = S_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SH_RD: begin
                o_cmd.rd_prev = 1'b1;
                n_state       = S_SH_WR;
            end
            S_SH_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_dec  = 1'b1;
                n_state        = i_stat.idxm1_eq_pos ? S_WRITE : S_SH_RD;
            end
            S_WRITE: begin
                o_cmd.wr_value = 1'b1;
                n_state        = S_DONE;
            end
            S_RD: begin
                o_cmd.rd_cur = 1'b1;
                n_state      = S_RD_W;
            end
            S_RD_W: begin
                o_cmd.prime_start = 1'b1;
                n_state           = S_PRIME;
            end
            S_PRIME: begin
                if (i_stat.prime_done) begin
                    o_cmd.acc_add = 1'b1;
                    if (i_stat.idx_last) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_RD;
                    end
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire
